FILE: rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared codes and controller/datapath interface types for the page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int CHUNK_W = 6;

   localparam logic [1:0] KIND_WRITE     = 2'd0;
   localparam logic [1:0] KIND_REMOVE    = 2'd1;
   localparam logic [1:0] KIND_READ_TYPE = 2'd2;
   localparam logic [1:0] KIND_READ_REC  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;

   localparam logic [1:0] TYPE_BAD = 2'd3;

   typedef struct packed {
      logic       latch;
      logic       walk_init;
      logic       walk_step;
      logic       rd_p;
      logic       rd_free;
      logic       rd_prv;
      logic       cnt_inc;
      logic       alloc_init;
      logic       alloc_fresh;
      logic       alloc_pop;
      logic       rm_init;
      logic       rm_step;
      logic       rm_fix;
      logic       rd_init;
      logic       rd_step;
      logic       emit_err;
      logic [1:0] err_code;
   } cpa_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       bad_type;
      logic       write_bad;
      logic       sp_none;
      logic       head_none;
      logic       space_ok;
      logic       p_none;
      logic       free_none;
      logic       alloc_last;
      logic       rm_end;
      logic       rd_end;
   } cpa_stat_type;

endpackage

FILE: rtl/chained_page_allocator.sv
// ----------------------------------------------------------------------------
// chained_page_allocator
// Linked-page record store: allocates, frees and walks page chains per type.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         kind, record_type, data_bytes,
//                                 start, following and previous pages
//  response  rsp_strobe (1 cycle) status, page_id, chunk_index, next, last
//
//  A write uses fresh pages and pages reused from the free list; when fresh
//  pages do not cover it, free pages are probed first, and too few of them
//  give a refusal for space. Remove and read walk the chain page by page.
//  Reset is synchronous; the link memory needs no clearing pass.
//  The receiver cannot stall: each response is valid for one cycle only.
// ----------------------------------------------------------------------------
module chained_page_allocator #(
   parameter int NUM_PAGES        = 1024,
   parameter int PAGE_BYTES       = 1024,
   parameter int MAX_RECORD_PAGES = 64,
   localparam int PW              = $clog2(NUM_PAGES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_kind,
   input  logic [1:0]    req_record_type,
   input  logic [16:0]   req_data_bytes,
   input  logic [PW-1:0] req_start_page,
   input  logic [PW-1:0] req_following_record_page,
   input  logic [PW-1:0] req_previous_last_page,
   output logic          rsp_strobe,
   output logic [1:0]    rsp_status,
   output logic [PW-1:0] rsp_page_id,
   output logic [cpa_pkg::CHUNK_W-1:0] rsp_chunk_index,
   output logic [PW-1:0] rsp_next_record_page,
   output logic          rsp_last
);
   import cpa_pkg::*;

   cpa_cmd_type  cmd;
   cpa_stat_type stat;

   cpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cpa_datapath #(
      .NUM_PAGES        (NUM_PAGES),
      .PAGE_BYTES       (PAGE_BYTES),
      .MAX_RECORD_PAGES (MAX_RECORD_PAGES),
      .PW               (PW)
   ) u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .req_kind                  (req_kind),
      .req_record_type           (req_record_type),
      .req_data_bytes            (req_data_bytes),
      .req_start_page            (req_start_page),
      .req_following_record_page (req_following_record_page),
      .req_previous_last_page    (req_previous_last_page),
      .rsp_strobe                (rsp_strobe),
      .rsp_status                (rsp_status),
      .rsp_page_id               (rsp_page_id),
      .rsp_chunk_index           (rsp_chunk_index),
      .rsp_next_record_page      (rsp_next_record_page),
      .rsp_last                  (rsp_last)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> rsp_last)
      else $error("error response not final");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after final response");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("response without work in flight");

endmodule

FILE: rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for write, remove and read walks over the link memory.
// ----------------------------------------------------------------------------
module cpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cpa_pkg::cpa_stat_type stat,
   output cpa_pkg::cpa_cmd_type  cmd
);
   import cpa_pkg::*;

   typedef enum logic [3:0] {
      IDLE, DECODE, FW_CHK, FW_WAIT, AL_SEL, AL_POP,
      RM_RD, RM_WAIT, RM_PRV, RM_FIX, RD_RD, RD_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   assign busy = busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = DECODE;
            end
         end
         DECODE: begin
            case (stat.kind)
               KIND_WRITE: begin
                  if (stat.write_bad) begin
                     cmd.emit_err = 1'b1;
                     cmd.err_code = ST_INVALID;
                     state_in     = IDLE;
                  end else if (stat.space_ok) begin
                     cmd.alloc_init = 1'b1;
                     state_in       = AL_SEL;
                  end else begin
                     cmd.walk_init = 1'b1;
                     state_in      = FW_CHK;
                  end
               end
               KIND_REMOVE: begin
                  if (stat.bad_type || stat.sp_none) begin
                     cmd.emit_err = 1'b1;
                     cmd.err_code = ST_INVALID;
                     state_in     = IDLE;
                  end else begin
                     cmd.rm_init = 1'b1;
                     state_in    = RM_RD;
                  end
               end
               KIND_READ_TYPE: begin
                  if (stat.bad_type || stat.head_none) begin
                     cmd.emit_err = 1'b1;
                     cmd.err_code = ST_INVALID;
                     state_in     = IDLE;
                  end else begin
                     cmd.rd_init = 1'b1;
                     state_in    = RD_RD;
                  end
               end
               default: begin
                  if (stat.sp_none) begin
                     cmd.emit_err = 1'b1;
                     cmd.err_code = ST_INVALID;
                     state_in     = IDLE;
                  end else begin
                     cmd.rd_init = 1'b1;
                     state_in    = RD_RD;
                  end
               end
            endcase
         end
         FW_CHK: begin
            if (stat.space_ok) begin
               cmd.alloc_init = 1'b1;
               state_in       = AL_SEL;
            end else if (stat.p_none) begin
               cmd.emit_err = 1'b1;
               cmd.err_code = ST_NO_SPACE;
               state_in     = IDLE;
            end else begin
               cmd.rd_p    = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = FW_WAIT;
            end
         end
         FW_WAIT: begin
            cmd.walk_step = 1'b1;
            state_in      = FW_CHK;
         end
         AL_SEL: begin
            if (stat.free_none) begin
               cmd.alloc_fresh = 1'b1;
               if (stat.alloc_last) state_in = IDLE;
            end else begin
               cmd.rd_free = 1'b1;
               state_in    = AL_POP;
            end
         end
         AL_POP: begin
            cmd.alloc_pop = 1'b1;
            state_in      = stat.alloc_last ? IDLE : AL_SEL;
         end
         RM_RD: begin
            cmd.rd_p = 1'b1;
            state_in = RM_WAIT;
         end
         RM_WAIT: begin
            cmd.rm_step = 1'b1;
            state_in    = stat.rm_end ? RM_PRV : RM_RD;
         end
         RM_PRV: begin
            cmd.rd_prv = 1'b1;
            state_in   = RM_FIX;
         end
         RM_FIX: begin
            cmd.rm_fix = 1'b1;
            state_in   = IDLE;
         end
         RD_RD: begin
            cmd.rd_p = 1'b1;
            state_in = RD_WAIT;
         end
         RD_WAIT: begin
            cmd.rd_step = 1'b1;
            state_in    = stat.rd_end ? IDLE : RD_RD;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

endmodule

FILE: rtl/cpa_datapath.sv
// ----------------------------------------------------------------------------
// cpa_datapath
// Link memory, list heads, walk registers and the result register.
// ----------------------------------------------------------------------------
module cpa_datapath #(
   parameter int NUM_PAGES        = 1024,
   parameter int PAGE_BYTES       = 1024,
   parameter int MAX_RECORD_PAGES = 64,
   parameter int PW               = $clog2(NUM_PAGES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpa_pkg::cpa_cmd_type   cmd,
   output cpa_pkg::cpa_stat_type  stat,
   input  logic [1:0]             req_kind,
   input  logic [1:0]             req_record_type,
   input  logic [16:0]            req_data_bytes,
   input  logic [PW-1:0]          req_start_page,
   input  logic [PW-1:0]          req_following_record_page,
   input  logic [PW-1:0]          req_previous_last_page,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [PW-1:0]          rsp_page_id,
   output logic [cpa_pkg::CHUNK_W-1:0] rsp_chunk_index,
   output logic [PW-1:0]          rsp_next_record_page,
   output logic                   rsp_last
);
   import cpa_pkg::*;

   localparam int AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int EW  = PW + 1;
   localparam int DW  = 23;
   localparam int QW  = 7;
   localparam logic [PW-1:0] NONE = PW'(NUM_PAGES);
   localparam logic [DW-1:0] MAX_BYTES = DW'(MAX_RECORD_PAGES * PAGE_BYTES);
   localparam logic [CHUNK_W-1:0] K_LAST = CHUNK_W'(MAX_RECORD_PAGES - 1);

   logic [EW-1:0] mem [NUM_PAGES];
   logic [EW-1:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic          rd_en;

   logic [1:0]    kind_ff, t_ff;
   logic [PW-1:0] sp_ff, fol_ff, prv_ff;
   logic [QW-1:0] pages_ff, pages_in;
   logic          write_bad_ff, write_bad_in;

   logic [PW-1:0] heads_ff [3];
   logic [PW-1:0] free_head_ff, fresh_ff;
   logic [PW-1:0] p_ff, nxt_ff, guard_ff;
   logic          cont_ff;
   logic [QW-1:0] cnt_ff, left_ff;
   logic [CHUNK_W-1:0] k_ff;

   logic          strobe_ff;
   logic [1:0]    status_ff;
   logic [PW-1:0] page_ff, next_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic          last_ff;

   logic [PW-1:0] head_sel, fresh_avail, pg, rd_next;
   logic          rd_cont;
   logic [PW:0]   space_sum;

   function automatic logic [PW-1:0] norm(input logic [PW-1:0] v);
      norm = (v < NONE) ? v : NONE;
   endfunction

   // pages = floor((bytes - 1) / PAGE_BYTES) + 1, six restoring steps
   always_comb begin
      logic [DW-1:0] rem;
      logic [QW-1:0] q;
      rem = DW'(req_data_bytes) - DW'(1);
      q   = '0;
      for (int b = 5; b >= 0; b--) begin
         if (rem >= (DW'(PAGE_BYTES) << b)) begin
            rem  = rem - (DW'(PAGE_BYTES) << b);
            q[b] = 1'b1;
         end
      end
      pages_in     = q + QW'(1);
      write_bad_in = (req_data_bytes == 17'd0) || (DW'(req_data_bytes) > MAX_BYTES);
   end

   assign rd_next     = rdata_ff[PW-1:0];
   assign rd_cont     = rdata_ff[PW];
   assign head_sel    = (t_ff == TYPE_BAD) ? NONE : heads_ff[t_ff];
   assign fresh_avail = NONE - fresh_ff;
   assign space_sum   = (PW+1)'(cnt_ff) + (PW+1)'(fresh_avail);
   assign pg          = cmd.alloc_pop ? free_head_ff : fresh_ff;

   always_comb begin
      stat.kind       = kind_ff;
      stat.bad_type   = (t_ff == TYPE_BAD);
      stat.write_bad  = write_bad_ff || (t_ff == TYPE_BAD);
      stat.sp_none    = (sp_ff == NONE);
      stat.head_none  = (head_sel == NONE);
      stat.space_ok   = (space_sum >= (PW+1)'(pages_ff));
      stat.p_none     = (p_ff >= NONE);
      stat.free_none  = (free_head_ff >= NONE);
      stat.alloc_last = (left_ff == QW'(1));
      stat.rm_end     = !rd_cont || (rd_next >= NONE) || (guard_ff == NONE - PW'(1));
      stat.rd_end     = !rd_cont || (k_ff == K_LAST) || (rd_next >= NONE);
   end

   always_comb begin
      rd_en = cmd.rd_p || cmd.rd_free || cmd.rd_prv;
      raddr = p_ff[AW-1:0];
      if (cmd.rd_free) raddr = free_head_ff[AW-1:0];
      if (cmd.rd_prv)  raddr = prv_ff[AW-1:0];
   end

   // link memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[raddr];
      if (cmd.alloc_fresh || cmd.alloc_pop) begin
         mem[pg[AW-1:0]] <= {cont_ff, nxt_ff};
      end else if (cmd.rm_step) begin
         mem[p_ff[AW-1:0]] <= {1'b0, free_head_ff};
      end else if (cmd.rm_fix && (prv_ff != NONE)) begin
         mem[prv_ff[AW-1:0]] <= {rd_cont, fol_ff};
      end
   end

   // request capture and walk registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff      <= req_kind;
         t_ff         <= req_record_type;
         sp_ff        <= norm(req_start_page);
         fol_ff       <= norm(req_following_record_page);
         prv_ff       <= norm(req_previous_last_page);
         pages_ff     <= pages_in;
         write_bad_ff <= write_bad_in;
         cnt_ff       <= '0;
      end
      if (cmd.walk_init) p_ff <= free_head_ff;
      if (cmd.walk_step) p_ff <= rd_next;
      if (cmd.cnt_inc)   cnt_ff <= cnt_ff + QW'(1);
      if (cmd.alloc_init) begin
         nxt_ff  <= head_sel;
         cont_ff <= 1'b0;
         left_ff <= pages_ff;
      end
      if (cmd.alloc_fresh || cmd.alloc_pop) begin
         nxt_ff  <= pg;
         cont_ff <= 1'b1;
         left_ff <= left_ff - QW'(1);
      end
      if (cmd.rm_init) begin
         p_ff     <= sp_ff;
         guard_ff <= '0;
      end
      if (cmd.rm_step) begin
         p_ff     <= rd_next;
         guard_ff <= guard_ff + PW'(1);
      end
      if (cmd.rd_init) begin
         p_ff <= (kind_ff == KIND_READ_TYPE) ? head_sel : sp_ff;
         k_ff <= '0;
      end
      if (cmd.rd_step) begin
         p_ff <= rd_next;
         k_ff <= k_ff + CHUNK_W'(1);
      end
   end

   // list heads and fresh mark
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) heads_ff[i] <= NONE;
         free_head_ff <= NONE;
         fresh_ff     <= '0;
      end else begin
         if (cmd.alloc_fresh) fresh_ff <= fresh_ff + PW'(1);
         if (cmd.alloc_pop)   free_head_ff <= rd_next;
         if (cmd.alloc_fresh || cmd.alloc_pop) heads_ff[t_ff] <= pg;
         if (cmd.rm_step)     free_head_ff <= p_ff;
         if (cmd.rm_fix && (heads_ff[t_ff] == sp_ff)) heads_ff[t_ff] <= fol_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_err || cmd.alloc_fresh || cmd.alloc_pop
                      || cmd.rm_fix || cmd.rd_step;
      end
      if (cmd.alloc_fresh || cmd.alloc_pop) begin
         status_ff <= ST_OK;
         page_ff   <= pg;
         chunk_ff  <= CHUNK_W'(left_ff - QW'(1));
         next_ff   <= NONE;
         last_ff   <= (left_ff == QW'(1));
      end else if (cmd.rd_step) begin
         status_ff <= ST_OK;
         page_ff   <= p_ff;
         chunk_ff  <= k_ff;
         next_ff   <= stat.rd_end ? rd_next : NONE;
         last_ff   <= stat.rd_end;
      end else begin
         status_ff <= cmd.emit_err ? cmd.err_code : ST_OK;
         page_ff   <= NONE;
         chunk_ff  <= '0;
         next_ff   <= NONE;
         last_ff   <= 1'b1;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_page_id          = page_ff;
   assign rsp_chunk_index      = chunk_ff;
   assign rsp_next_record_page = next_ff;
   assign rsp_last             = last_ff;

endmodule
